// ===== rtl/lcgrpe_pkg.sv =====
package lcgrpe_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam int LCG_SHIFT = 16;

  localparam logic [1:0] FUNC_DRAW = 2'd0;
  localparam logic [1:0] FUNC_SEED = 2'd1;
  localparam logic [1:0] FUNC_SHUF = 2'd2;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_SEED = 2'd1,
    OP_SHUF = 2'd2
  } op_t;

  // Count is already saturated to the table size, so it never grows past 7 bits.
  typedef struct packed {
    op_t         op;
    logic [15:0] bound;
    logic [31:0] new_seed;
    logic [6:0]  count;
  } cmd_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    lcg_next = s * LCG_MUL + LCG_ADD;
  endfunction

endpackage

// ===== rtl/lcgrpe_if.sv =====
interface lcgrpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] bound;
  logic [31:0] new_seed;
  logic [6:0]  count;

  modport source (output valid, func, bound, new_seed, count, input ready);
  modport sink (input valid, func, bound, new_seed, count, output ready);
endinterface

interface lcgrpe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        last;
  logic [31:0] seed_now;

  modport source (output valid, value, last, seed_now, input ready);
  modport sink (input valid, value, last, seed_now, output ready);
endinterface

// ===== rtl/lcgrpe_front.sv =====
module lcgrpe_front #(
  parameter int MAX_ENTRIES = lcgrpe_pkg::DEF_MAX_ENTRIES
) (
  lcgrpe_in_if.sink          req,
  input  logic               push_ready,
  output logic               push_valid,
  output lcgrpe_pkg::cmd_t   push_cmd
);

  localparam int SW = ($clog2(MAX_ENTRIES + 1) > 7) ? $clog2(MAX_ENTRIES + 1) : 7;

  logic [SW-1:0] count_ext;
  logic [SW-1:0] count_sat;
  logic          keep;

  assign count_ext = SW'(req.count);
  assign count_sat = (count_ext > SW'(MAX_ENTRIES)) ? SW'(MAX_ENTRIES) : count_ext;

  // Unused selectors and empty shuffles leave no trace, so they never enter the queue.
  always_comb begin
    keep = 1'b0;
    push_cmd.op = lcgrpe_pkg::OP_DRAW;
    push_cmd.bound = req.bound;
    push_cmd.new_seed = req.new_seed;
    push_cmd.count = 7'(count_sat);
    unique case (req.func)
      lcgrpe_pkg::FUNC_DRAW: begin
        keep = 1'b1;
        push_cmd.op = lcgrpe_pkg::OP_DRAW;
      end
      lcgrpe_pkg::FUNC_SEED: begin
        keep = 1'b1;
        push_cmd.op = lcgrpe_pkg::OP_SEED;
      end
      lcgrpe_pkg::FUNC_SHUF: begin
        keep = (count_sat != '0);
        push_cmd.op = lcgrpe_pkg::OP_SHUF;
      end
      default: begin
        keep = 1'b0;
        push_cmd.op = lcgrpe_pkg::OP_DRAW;
      end
    endcase
  end

  assign req.ready = push_ready;
  assign push_valid = req.valid && keep;

endmodule

// ===== rtl/lcgrpe_queue.sv =====
module lcgrpe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  lcgrpe_pkg::cmd_t push_cmd,
  output logic             push_ready,
  output logic             pop_valid,
  output lcgrpe_pkg::cmd_t pop_cmd,
  input  logic             pop_ready
);

  localparam int PW = $clog2(lcgrpe_pkg::QUEUE_DEPTH);
  localparam int FW = $clog2(lcgrpe_pkg::QUEUE_DEPTH + 1);

  lcgrpe_pkg::cmd_t slots [lcgrpe_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != FW'(lcgrpe_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(lcgrpe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(lcgrpe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + FW'(do_push) - FW'(do_pop);
    end
  end

endmodule

// ===== rtl/lcgrpe_back.sv =====
module lcgrpe_back #(
  parameter int MAX_ENTRIES = lcgrpe_pkg::DEF_MAX_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  lcgrpe_pkg::cmd_t pop_cmd,
  output logic             pop_ready,
  lcgrpe_out_if.source     rsp
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_D_MUL  = 11'b00000000010,
    S_D_OUT  = 11'b00000000100,
    S_FILL   = 11'b00000001000,
    S_SW_ADV = 11'b00000010000,
    S_SW_MUL = 11'b00000100000,
    S_SW_RD  = 11'b00001000000,
    S_SW_W1  = 11'b00010000000,
    S_SW_W2  = 11'b00100000000,
    S_E_RD   = 11'b01000000000,
    S_E_OUT  = 11'b10000000000
  } state_t;

  state_t        state;
  logic [31:0]   seed;
  logic [15:0]   bnd;
  logic [31:0]   prod;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic [CW-1:0] j_comb;
  logic [16:0]   j_wide;
  logic [15:0]   mul_b;
  logic          idx_last;

  logic [AW-1:0] mem [MAX_ENTRIES];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_wd;
  logic          rd_en;
  logic [AW-1:0] rd_a;
  logic [AW-1:0] rd_b;

  logic          out_free;
  logic          out_load;

  assign pop_ready = (state == S_IDLE);
  assign idx_last = (idx == n - CW'(1));
  assign out_free = !rsp.valid || rsp.ready;
  assign out_load = out_free && ((state == S_D_OUT) || (state == S_E_OUT));

  assign mul_b = (state == S_D_MUL) ? bnd : 16'(n - idx);

  // The swap partner is i plus the draw; it is clamped to the table end for safety.
  assign j_wide = 17'(prod[31:16]) + 17'(idx);
  assign j_comb = (j_wide >= 17'(n)) ? n - CW'(1) : CW'(j_wide);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx[AW-1:0];
    mem_wd = idx[AW-1:0];
    case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_SW_W1: begin
        mem_we = 1'b1;
        mem_wd = rd_b;
      end
      S_SW_W2: begin
        mem_we = 1'b1;
        mem_wa = jdx[AW-1:0];
        mem_wd = rd_a;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign rd_en = (state == S_SW_RD) || (state == S_E_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_a <= mem[idx[AW-1:0]];
      rd_b <= mem[j_comb[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_D_MUL || state == S_SW_MUL) begin
      prod <= seed[31:16] * mul_b;
    end
    if (state == S_SW_RD) begin
      jdx <= j_comb;
    end
    if (state == S_IDLE && pop_valid) begin
      bnd <= pop_cmd.bound;
      n <= CW'(pop_cmd.count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seed <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (pop_valid) begin
            unique case (pop_cmd.op)
              lcgrpe_pkg::OP_DRAW: begin
                seed <= lcgrpe_pkg::lcg_next(seed);
                state <= S_D_MUL;
              end
              lcgrpe_pkg::OP_SEED: begin
                seed <= pop_cmd.new_seed;
              end
              lcgrpe_pkg::OP_SHUF: begin
                state <= S_FILL;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_D_MUL: state <= S_D_OUT;
        S_D_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          if (idx_last) begin
            idx <= '0;
            state <= S_SW_ADV;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SW_ADV: begin
          seed <= lcgrpe_pkg::lcg_next(seed);
          state <= S_SW_MUL;
        end
        S_SW_MUL: state <= S_SW_RD;
        S_SW_RD:  state <= S_SW_W1;
        S_SW_W1:  state <= S_SW_W2;
        S_SW_W2: begin
          if (idx_last) begin
            idx <= '0;
            state <= S_E_RD;
          end else begin
            idx <= idx + CW'(1);
            state <= S_SW_ADV;
          end
        end
        S_E_RD: state <= S_E_OUT;
        S_E_OUT: begin
          if (out_free) begin
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
              state <= S_E_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.seed_now <= seed;
      if (state == S_D_OUT) begin
        rsp.value <= prod[31:16];
        rsp.last <= 1'b1;
      end else begin
        rsp.value <= 16'(rd_a);
        rsp.last <= idx_last;
      end
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |-> (state == S_IDLE))
    else $error("command taken while busy");

  a_partner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_W1) |-> ((jdx >= idx) && (jdx < n)))
    else $error("swap partner outside the live table");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL || state == S_SW_RD || state == S_E_OUT) |-> (idx < n))
    else $error("table index beyond shuffle count");

  a_shuffle_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_OUT && out_free && idx_last) |=> (rsp.valid && rsp.last))
    else $error("final permutation word not marked last");

endmodule

// ===== rtl/lcg_random_and_permutation_engine_top.sv =====
// Random source with a 32-bit linear congruential seed and a permutation shuffler.
// A draw steps the seed and takes the bounded multiply before its output word is loaded;
// a reseed only replaces the seed. A shuffle of n entries leaves the queue, fills the
// table, runs five steps per swap (seed step, bounded multiply, two-port table read,
// two single-port writes), then emits each word after a registered table read. The table
// memory's single write port splits each swap's write into two steps, and each swap
// multiplies the upper 16 seed bits by the remaining count. Each word carries the seed as it
// stands after the whole command. Commands enter a two-deep queue, so the next ones are
// taken while the current one runs; unused selectors and shuffles of zero are dropped
// before it, and counts above the table size are cut to it.
module lcg_random_and_permutation_engine_top #(
  parameter int MAX_ENTRIES = lcgrpe_pkg::DEF_MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  lcgrpe_in_if.sink    req,
  lcgrpe_out_if.source rsp
);

  logic             push_valid;
  logic             push_ready;
  lcgrpe_pkg::cmd_t push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  lcgrpe_pkg::cmd_t pop_cmd;

  lcgrpe_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .req        (req),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  lcgrpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  lcgrpe_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule
